// ===== hw/rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// Type codes, pipeline stage records and helpers for the numeric type converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam logic [2:0] TY_I8  = 3'd0;
    localparam logic [2:0] TY_I16 = 3'd1;
    localparam logic [2:0] TY_I32 = 3'd2;
    localparam logic [2:0] TY_I64 = 3'd3;
    localparam logic [2:0] TY_F32 = 3'd4;
    localparam logic [2:0] TY_F64 = 3'd5;

    localparam int NUM_STAGES = 5;

    // operation class carried down the pipe
    localparam logic [1:0] OP_RAW = 2'd0;  // result already final in res
    localparam logic [1:0] OP_TOF = 2'd1;  // finite nonzero value to float
    localparam logic [1:0] OP_TOI = 2'd2;  // float to integer

    typedef struct packed {
        logic [1:0]         op;
        logic               flag;
        logic               written;
        logic [63:0]        res;
        logic               sign;
        logic               inf;
        logic [63:0]        mag;
        logic signed [12:0] exp;
        logic [2:0]         dst;
    } ntc_s1_t;

    typedef struct packed {
        ntc_s1_t    base;
        logic [5:0] lz;
    } ntc_s2_t;

    typedef struct packed {
        logic [1:0]         op;
        logic               flag;
        logic               written;
        logic [63:0]        res;
        logic               sign;
        logic               inf;
        logic [63:0]        norm;
        logic signed [12:0] ex;
        logic [2:0]         dst;
    } ntc_s3_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        flag;
        logic        written;
        logic [63:0] res;
        logic        sign;
        logic [63:0] kept;
        logic        guard;
        logic        sticky;
        logic [10:0] ebias;
        logic        ovf;
        logic        big;
        logic [2:0]  dst;
    } ntc_s4_t;

    typedef struct packed {
        logic [63:0] res;
        logic        written;
        logic        flag;
    } ntc_out_t;

    function automatic logic [63:0] width_mask(input logic [2:0] t);
        logic [63:0] m;
        case (t)
            TY_I8:   m = 64'h0000_0000_0000_00ff;
            TY_I16:  m = 64'h0000_0000_0000_ffff;
            TY_I32:  m = 64'h0000_0000_ffff_ffff;
            TY_F32:  m = 64'h0000_0000_ffff_ffff;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [2:0] t, input logic [63:0] v);
        logic [63:0] r;
        case (t)
            TY_I8:   r = {{56{v[7]}}, v[7:0]};
            TY_I16:  r = {{48{v[15]}}, v[15:0]};
            TY_I32:  r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] lead_zeros(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                n = 6'(63 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/ntc_if.sv =====
// ----------------------------------------------------------------------------
// ntc_req_if / ntc_rsp_if
// Valid/ready channels carrying conversion requests and results.
// ----------------------------------------------------------------------------
interface ntc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [2:0]  target_type;
    logic [63:0] source_bits;

    modport source (output valid, func, target_type, source_bits, input ready);
    modport sink   (input valid, func, target_type, source_bits, output ready);
endinterface

interface ntc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        written;
    logic        range_flag;

    modport source (output valid, result_bits, written, range_flag, input ready);
    modport sink   (input valid, result_bits, written, range_flag, output ready);
endinterface

// ===== hw/rtl/ntc_datapath.sv =====
// ----------------------------------------------------------------------------
// ntc_datapath
// Five register stages: decode, leading-zero count, normalize, align, round/pack.
// ----------------------------------------------------------------------------
module ntc_datapath
(
    input  logic                          clk,
    input  logic [ntc_pkg::NUM_STAGES-1:0] load,
    input  logic [2:0]                    func,
    input  logic [2:0]                    target_type,
    input  logic [63:0]                   source_bits,
    output ntc_pkg::ntc_out_t             result
);
    import ntc_pkg::*;

    ntc_s1_t  s1_reg, s1_next;
    ntc_s2_t  s2_reg, s2_next;
    ntc_s3_t  s3_reg, s3_next;
    ntc_s4_t  s4_reg, s4_next;
    ntc_out_t s5_reg, s5_next;

    // ---------------- stage 1: decode ----------------
    always_comb
    begin
        logic [63:0] v;
        logic        is32;
        logic        fs;
        logic [10:0] fe;
        logic [51:0] ff;
        logic        f_nan;
        logic        f_inf;
        logic        f_zero;
        logic [63:0] nan_pat;
        logic [63:0] inf_pat;
        logic [63:0] zero_pat;

        v    = sign_ext(func, source_bits);
        is32 = (func == TY_F32);
        if (is32)
        begin
            fs = source_bits[31];
            fe = {3'b0, source_bits[30:23]};
            ff = {29'b0, source_bits[22:0]};
            f_nan  = (source_bits[30:23] == 8'hff) && (source_bits[22:0] != 23'b0);
            f_inf  = (source_bits[30:23] == 8'hff) && (source_bits[22:0] == 23'b0);
        end
        else
        begin
            fs = source_bits[63];
            fe = source_bits[62:52];
            ff = source_bits[51:0];
            f_nan  = (fe == 11'h7ff) && (ff != 52'b0);
            f_inf  = (fe == 11'h7ff) && (ff == 52'b0);
        end
        f_zero = (fe == 11'b0) && (ff == 52'b0);

        // patterns in the target format (cross float conversion only)
        if (target_type == TY_F64)
        begin
            nan_pat  = {fs, 11'h7ff, 1'b1, source_bits[21:0], 29'b0};
            inf_pat  = {fs, 11'h7ff, 52'b0};
            zero_pat = {fs, 63'b0};
        end
        else
        begin
            nan_pat  = {32'b0, fs, 8'hff, 1'b1, source_bits[50:29]};
            inf_pat  = {32'b0, fs, 8'hff, 23'b0};
            zero_pat = {32'b0, fs, 31'b0};
        end

        s1_next         = '0;
        s1_next.dst     = target_type;
        s1_next.op      = OP_RAW;
        s1_next.written = (func <= TY_F64) && (target_type <= TY_F64);

        if (!s1_next.written)
        begin
            s1_next.res = '0;
        end
        else if (func <= TY_I64)
        begin
            s1_next.sign = v[63];
            s1_next.mag  = v[63] ? (~v + 64'd1) : v;
            s1_next.exp  = 13'sd0;
            if (target_type <= TY_I64)
            begin
                s1_next.res = v & width_mask(target_type);
            end
            else if (v != 64'b0)
            begin
                s1_next.op = OP_TOF;
            end
        end
        else
        begin
            s1_next.sign = fs;
            s1_next.inf  = f_inf;
            if (is32)
            begin
                s1_next.mag = {40'b0, (fe != 11'b0), ff[22:0]};
                s1_next.exp = $signed({2'b0, (fe == 11'b0) ? 11'd1 : fe}) - 13'sd150;
            end
            else
            begin
                s1_next.mag = {11'b0, (fe != 11'b0), ff};
                s1_next.exp = $signed({2'b0, (fe == 11'b0) ? 11'd1 : fe}) - 13'sd1075;
            end

            if (target_type <= TY_I64)
            begin
                if (f_nan)
                begin
                    s1_next.flag = 1'b1;
                end
                else if (!f_zero)
                begin
                    s1_next.op = OP_TOI;
                end
            end
            else if (target_type == func)
            begin
                s1_next.res = source_bits & width_mask(target_type);
            end
            else if (f_nan)
            begin
                s1_next.res = nan_pat;
            end
            else if (f_inf)
            begin
                s1_next.res = inf_pat;
            end
            else if (f_zero)
            begin
                s1_next.res = zero_pat;
            end
            else
            begin
                s1_next.op = OP_TOF;
            end
        end
    end

    // ---------------- stage 2: leading zeros ----------------
    always_comb
    begin
        s2_next.base = s1_reg;
        s2_next.lz   = lead_zeros(s1_reg.mag);
    end

    // ---------------- stage 3: normalize, msb at bit 63 ----------------
    always_comb
    begin
        s3_next.op      = s2_reg.base.op;
        s3_next.flag    = s2_reg.base.flag;
        s3_next.written = s2_reg.base.written;
        s3_next.res     = s2_reg.base.res;
        s3_next.sign    = s2_reg.base.sign;
        s3_next.inf     = s2_reg.base.inf;
        s3_next.dst     = s2_reg.base.dst;
        s3_next.norm    = s2_reg.base.mag << s2_reg.lz;
        s3_next.ex      = s2_reg.base.exp + 13'sd63 - $signed({7'b0, s2_reg.lz});
    end

    // ---------------- stage 4: align to target ----------------
    always_comb
    begin
        logic signed [12:0] emin;
        logic signed [12:0] emax;
        logic signed [12:0] bias_m1;
        logic [6:0]         base_sh;
        logic signed [12:0] den;
        logic [6:0]         sh;
        logic [127:0]       wide;
        logic signed [12:0] eb;

        if (s3_reg.dst == TY_F32)
        begin
            emin    = -13'sd126;
            emax    = 13'sd127;
            bias_m1 = 13'sd126;
            base_sh = 7'd40;
        end
        else
        begin
            emin    = -13'sd1022;
            emax    = 13'sd1023;
            bias_m1 = 13'sd1022;
            base_sh = 7'd11;
        end

        den = emin - s3_reg.ex;
        if (den > 13'sd80)
        begin
            sh = 7'd127;
        end
        else if (den > 13'sd0)
        begin
            sh = base_sh + den[6:0];
        end
        else
        begin
            sh = base_sh;
        end
        wide = {s3_reg.norm, 64'b0} >> sh;
        eb   = s3_reg.ex + bias_m1;

        s4_next         = '0;
        s4_next.op      = s3_reg.op;
        s4_next.flag    = s3_reg.flag;
        s4_next.written = s3_reg.written;
        s4_next.res     = s3_reg.res;
        s4_next.sign    = s3_reg.sign;
        s4_next.dst     = s3_reg.dst;

        if (s3_reg.op == OP_TOI)
        begin
            s4_next.big = s3_reg.inf || (s3_reg.ex > 13'sd63);
            if (s3_reg.ex < 13'sd0)
            begin
                s4_next.kept = '0;
            end
            else
            begin
                s4_next.kept = s3_reg.norm >> (6'd63 - s3_reg.ex[5:0]);
            end
        end
        else
        begin
            s4_next.kept   = wide[127:64];
            s4_next.guard  = wide[63];
            s4_next.sticky = |wide[62:0];
            s4_next.ebias  = (den > 13'sd0) ? 11'd0 : eb[10:0];
            s4_next.ovf    = s3_reg.ex > emax;
        end
    end

    // ---------------- stage 5: round, pack, saturate ----------------
    always_comb
    begin
        logic        inc;
        logic [31:0] p32;
        logic [63:0] p64;
        logic [63:0] lim;
        logic        sat;
        logic [63:0] ival;

        inc = s4_reg.guard & (s4_reg.sticky | s4_reg.kept[0]);
        p32 = {1'b0, s4_reg.ebias[7:0], 23'b0} + s4_reg.kept[31:0] + {31'b0, inc};
        p64 = {1'b0, s4_reg.ebias, 52'b0} + s4_reg.kept + {63'b0, inc};

        case (s4_reg.dst)
            TY_I8:   lim = 64'd1 << 7;
            TY_I16:  lim = 64'd1 << 15;
            TY_I32:  lim = 64'd1 << 31;
            default: lim = 64'd1 << 63;
        endcase
        sat  = s4_reg.big || (s4_reg.sign ? (s4_reg.kept > lim) : (s4_reg.kept >= lim));
        if (sat)
        begin
            ival = s4_reg.sign ? lim : (lim - 64'd1);
        end
        else
        begin
            ival = s4_reg.sign ? (~s4_reg.kept + 64'd1) : s4_reg.kept;
        end

        s5_next.written = s4_reg.written;
        s5_next.flag    = s4_reg.flag;
        case (s4_reg.op)
            OP_TOI:
            begin
                s5_next.res  = ival & width_mask(s4_reg.dst);
                s5_next.flag = sat;
            end
            OP_TOF:
            begin
                if (s4_reg.dst == TY_F32)
                begin
                    s5_next.res = s4_reg.ovf ? {32'b0, s4_reg.sign, 8'hff, 23'b0}
                                             : {32'b0, s4_reg.sign, p32[30:0]};
                end
                else
                begin
                    s5_next.res = s4_reg.ovf ? {s4_reg.sign, 11'h7ff, 52'b0}
                                             : {s4_reg.sign, p64[62:0]};
                end
            end
            default:
            begin
                s5_next.res = s4_reg.res;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_reg <= s1_next;
        end
        if (load[1])
        begin
            s2_reg <= s2_next;
        end
        if (load[2])
        begin
            s3_reg <= s3_next;
        end
        if (load[3])
        begin
            s4_reg <= s4_next;
        end
        if (load[4])
        begin
            s5_reg <= s5_next;
        end
    end

    assign result = s5_reg;

endmodule

// ===== hw/rtl/numeric_type_converter_top.sv =====
// ----------------------------------------------------------------------------
// numeric_type_converter_top
// Converts one value per beat between int8/16/32/64, single and double.
// ----------------------------------------------------------------------------
// One request beat enters per clock unless a stalled output has filled the pipe;
// decode, leading-zero count, normalize, align and round/pack each take one
// register stage. A stalled output only holds the stages that are full, so
// empty stages keep absorbing new beats until the pipe is completely full.
module numeric_type_converter_top
(
    input  logic      clk,
    input  logic      rst_n,
    ntc_req_if.sink   req,
    ntc_rsp_if.source rsp
);
    import ntc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] load;
    ntc_out_t              result;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rsp.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = req.valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    ntc_datapath u_datapath
    (
        .clk         (clk),
        .load        (load),
        .func        (req.func),
        .target_type (req.target_type),
        .source_bits (req.source_bits),
        .result      (result)
    );

    assign req.ready       = load[0];
    assign rsp.valid       = valid_reg[NUM_STAGES-1];
    assign rsp.result_bits = result.res;
    assign rsp.written     = result.written;
    assign rsp.range_flag  = result.flag;

endmodule
